@@ sv/signed_int_to_decimal_ascii_defines.svh @@
// Assertion macros used by the checker file of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define SIDA_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define SIDA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

@@ sv/sida_pkg.sv @@
// Shared types and constants of the signed integer to decimal text converter.
`default_nettype none

package sida_pkg;

	// Default width of the converted integer.
	localparam int DEF_NUMBER_WIDTH = 64;

	// Character codes.
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_SKIP,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture a new value and clear the digit register
		logic conv;        // one shift-and-adjust step of the binary to BCD pass
		logic shift_dig;   // drop a leading zero digit
		logic emit_sign;   // load '-' into the output register
		logic emit_digit;  // load the top digit into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;         // the captured value is negative
		logic conv_done;   // the current conversion step is the final one
		logic top_zero;    // the most significant remaining digit is zero
		logic one_left;    // only one digit remains
		logic out_free;    // the output register can take a character this cycle
	} dp_sts_t;

endpackage

`default_nettype wire

@@ sv/sida_datapath.sv @@
// Datapath: magnitude capture, bit-serial binary to BCD pass and character output register.
`default_nettype none

module sida_datapath
	import sida_pkg::*;
#(
	parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] value,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	// Digit count of the largest magnitude, 2^(NUMBER_WIDTH-1).
	localparam int NDIG   = ((NUMBER_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W  = 4 * NDIG;
	localparam int CNT_W  = $clog2(NUMBER_WIDTH);
	localparam int DCNT_W = $clog2(NDIG + 1);

	logic [NUMBER_WIDTH-1:0] x;
	logic [NUMBER_WIDTH-1:0] mag;
	logic [NUMBER_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [BCD_W-1:0]        bcd_adj;
	logic [3:0]              top_dig;
	logic                    neg_q;
	logic [CNT_W-1:0]        bit_cnt_q;
	logic [DCNT_W-1:0]       dig_left_q;
	logic                    out_valid_q;
	logic [6:0]              out_char_q;
	logic                    out_last_q;

	// Magnitude of the low bits taken as two's complement, formed as an unsigned value.
	assign x   = value[NUMBER_WIDTH-1:0];
	assign mag = x[NUMBER_WIDTH-1] ? ({NUMBER_WIDTH{1'b0}} - x) : x;

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_dig = bcd_q[BCD_W-1 -: 4];

	// Status toward the controller.
	assign sts.neg       = neg_q;
	assign sts.conv_done = (bit_cnt_q == CNT_W'(NUMBER_WIDTH - 1));
	assign sts.top_zero  = (top_dig == 4'd0);
	assign sts.one_left  = (dig_left_q == DCNT_W'(1));
	assign sts.out_free  = !out_valid_q || m_tready;

	// Counters and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			dig_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q  <= '0;
				dig_left_q <= DCNT_W'(NDIG);
			end else if (cmd.conv) begin
				bit_cnt_q <= bit_cnt_q + CNT_W'(1);
			end else if (cmd.shift_dig || cmd.emit_digit) begin
				dig_left_q <= dig_left_q - DCNT_W'(1);
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Value, digit and character registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= x[NUMBER_WIDTH-1];
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cmd.conv) begin
			bin_q <= {bin_q[NUMBER_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUMBER_WIDTH-1]};
		end else if (cmd.shift_dig || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (cmd.emit_sign) begin
			out_char_q <= CH_MINUS;
			out_last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			out_char_q <= CH_ZERO + {3'b000, top_dig};
			out_last_q <= sts.one_left;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ sv/sida_ctrl.sv @@
// Controller state machine: sequences conversion, leading zero removal and character output.
`default_nettype none

module sida_ctrl
	import sida_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_CONV;
			end
			S_CONV: begin
				if (sts.conv_done) state_d = S_SIGN;
			end
			S_SIGN: begin
				if (!sts.neg || sts.out_free) state_d = S_SKIP;
			end
			S_SKIP: begin
				if (!sts.top_zero || sts.one_left) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free && sts.one_left) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_CONV: begin
				cmd.conv = 1'b1;
			end
			S_SIGN: begin
				cmd.emit_sign = sts.neg && sts.out_free;
			end
			S_SKIP: begin
				cmd.shift_dig = sts.top_zero && !sts.one_left;
			end
			S_EMIT: begin
				cmd.emit_digit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/signed_int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII text converter.
//
// Usage: one signed integer enters on the slave stream (s_tdata, of which the low
// NUMBER_WIDTH bits are used as two's complement). Its decimal text leaves on the
// master stream, one character per transaction: '-' first for a negative value,
// then the digits most significant first without leading zeros; m_tlast marks
// the final digit. Zero yields a single '0'.
// Timing: one value is handled at a time. After acceptance, the binary to BCD
// pass takes one bit per cycle through the shift-and-adjust register, the sign
// is settled, leading zero digits are dropped one per cycle, and then one
// character is produced per cycle while the receiver takes them; s_tready rises
// again after the last digit has been loaded into the output register.
// Stalls: the output register holds a character until it is taken; the digit
// sequencer waits meanwhile and nothing is lost.
// Reset: arst_n clears the controller, the counters and the output valid flag; no value is
// kept from one transaction to the next.
`default_nettype none

module signed_int_to_decimal_ascii
	import sida_pkg::*;
#(
	parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
	output logic        m_tlast    // last_char
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer.
	sida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Conversion datapath and output register.
	sida_datapath #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ sv/sida_checker.sv @@
// Port checker of the decimal text converter and its bind to the top level.
`default_nettype none

`include "signed_int_to_decimal_ascii_defines.svh"

module sida_checker
	import sida_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// A stalled character stays on the output unchanged.
	`SIDA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	// Only a minus sign or a decimal digit ever appears.
	`SIDA_ASSERT_IMPL(a_char_set, m_tvalid, (m_tdata == {1'b0, CH_MINUS}) || ((m_tdata >= {1'b0, CH_ZERO}) && (m_tdata <= {1'b0, CH_ZERO} + 8'd9)), "character is neither sign nor digit")

	// The sign is never the final character of a number.
	`SIDA_ASSERT_IMPL(a_sign_not_last, m_tvalid && (m_tdata == {1'b0, CH_MINUS}), !m_tlast, "sign flagged as last")

	// A new value is not taken while the digits of a sign still have to follow.
	`SIDA_ASSERT_IMPL(a_busy_after_sign, m_tvalid && m_tready && (m_tdata == {1'b0, CH_MINUS}), !s_tready, "input ready before digits of a negative number")

	// After a value is taken, the converter is busy on the following cycle.
	`SIDA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready right after acceptance")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
